// ----- hw/rtl/gbte_pkg.sv -----
// Shared types and codes for the gap buffer text editor.
`timescale 1ns / 1ps

package gbte_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_FORWARD   = 3'd1,
    REQ_BACKWARD  = 3'd2,
    REQ_BACKSPACE = 3'd3,
    REQ_DELETE    = 3'd4,
    REQ_MOVE      = 3'd5,
    REQ_READ      = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOEFFECT = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DATA = 2'd2,
    S_OUT  = 2'd3
  } state_t;

endpackage

// ----- hw/rtl/gbte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gap_buffer_text_editor_top.sv -----
// Gap buffer text editor: the text sits in one CAPACITY x 8 RAM, the text before the cursor at
// the bottom and the text after it at the top, with the two lengths held in registers. One
// command is taken at a time: the block raises in_stall from the cycle after a command beat
// until its result is loaded into the output register. Insert, unused codes and any command
// that finds nothing to do go straight from execution to the output state; backspace, delete
// and read take one RAM read, then the capture; a move carries each crossed character with one
// RAM read followed by one write, and forward and backward are moves of one. While out_stall
// holds a waiting result, the next command stops in its last state and keeps in_stall high
// until the held beat leaves. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module gap_buffer_text_editor_top #(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [7:0]         in_char_in,
  input  logic signed [11:0] in_move_amount,
  input  logic [9:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [7:0]         out_char_out,
  output logic [10:0]        out_before_count,
  output logic [10:0]        out_after_count
);

  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int POS_W  = ((LEN_W > 10) ? LEN_W : 10) + 1;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  gbte_pkg::state_t  state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [7:0]        char_r, char_nxt;
  logic              back_r, back_nxt;
  logic [11:0]       rem_r, rem_nxt;
  logic [9:0]        pos_r, pos_nxt;
  logic [LEN_W-1:0]  before_len_r, before_len_nxt;
  logic [LEN_W-1:0]  after_len_r, after_len_nxt;
  gbte_pkg::status_t res_status_r, res_status_nxt;
  logic [7:0]        res_char_r, res_char_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [7:0]        out_char_r;
  logic [LEN_W-1:0]  out_before_r, out_after_r;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              in_beat, out_load;
  logic [LEN_W:0]    total_len;
  logic              full, step_ok, is_step;
  logic [POS_W-1:0]  pos_ext, before_ext, total_ext, read_addr;
  logic [11:0]       move_mag;
  logic [LEN_W+10:0] before_ext_out, after_ext_out;

  gbte_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != gbte_pkg::S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_load = (state_r == gbte_pkg::S_OUT) && (!out_valid_r || !out_stall);

  assign total_len  = {1'b0, before_len_r} + {1'b0, after_len_r};
  assign full       = (total_len >= {1'b0, CAP_LEN});
  assign step_ok    = back_r ? (before_len_r != '0) : (after_len_r != '0);
  assign is_step    = (req_r == gbte_pkg::REQ_FORWARD) || (req_r == gbte_pkg::REQ_BACKWARD) ||
                      (req_r == gbte_pkg::REQ_MOVE);
  assign pos_ext    = POS_W'(pos_r);
  assign before_ext = POS_W'(before_len_r);
  assign total_ext  = POS_W'(total_len);
  // Position after the cursor maps to the top block: CAPACITY - total + position
  assign read_addr  = (pos_ext < before_ext) ? pos_ext : (CAP_POS - total_ext + pos_ext);
  assign move_mag   = in_move_amount[11] ? (12'd0 - $unsigned(in_move_amount))
                                         : $unsigned(in_move_amount);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gbte_pkg::S_IDLE: begin
        if (in_beat) begin
          state_nxt = gbte_pkg::S_EXEC;
        end
      end
      gbte_pkg::S_EXEC: begin
        state_nxt = gbte_pkg::S_OUT;
        unique case (req_r)
          gbte_pkg::REQ_FORWARD, gbte_pkg::REQ_BACKWARD, gbte_pkg::REQ_MOVE: begin
            if (rem_r != '0 && step_ok) begin
              state_nxt = gbte_pkg::S_DATA;
            end
          end
          gbte_pkg::REQ_BACKSPACE: begin
            if (before_len_r != '0) begin
              state_nxt = gbte_pkg::S_DATA;
            end
          end
          gbte_pkg::REQ_DELETE: begin
            if (after_len_r != '0) begin
              state_nxt = gbte_pkg::S_DATA;
            end
          end
          gbte_pkg::REQ_READ: begin
            if (pos_ext < total_ext) begin
              state_nxt = gbte_pkg::S_DATA;
            end
          end
          default: state_nxt = gbte_pkg::S_OUT;
        endcase
      end
      gbte_pkg::S_DATA: begin
        state_nxt = is_step ? gbte_pkg::S_EXEC : gbte_pkg::S_OUT;
      end
      gbte_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = gbte_pkg::S_IDLE;
        end
      end
      default: state_nxt = gbte_pkg::S_IDLE;
    endcase
  end

  // Outputs: RAM control and datapath updates
  always_comb begin
    req_nxt        = req_r;
    char_nxt       = char_r;
    back_nxt       = back_r;
    rem_nxt        = rem_r;
    pos_nxt        = pos_r;
    before_len_nxt = before_len_r;
    after_len_nxt  = after_len_r;
    res_status_nxt = res_status_r;
    res_char_nxt   = res_char_r;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(before_len_r);
    ram_wdata      = char_r;
    ram_re         = 1'b0;
    ram_raddr      = ADDR_W'(before_len_r);

    unique case (state_r)
      gbte_pkg::S_IDLE: begin
        if (in_beat) begin
          req_nxt        = in_req_type;
          char_nxt       = in_char_in;
          pos_nxt        = in_position;
          res_status_nxt = gbte_pkg::ST_DONE;
          res_char_nxt   = 8'd0;
          // Forward and backward are moves of one character
          if (in_req_type == gbte_pkg::REQ_MOVE) begin
            back_nxt = in_move_amount[11];
            rem_nxt  = move_mag;
          end else begin
            back_nxt = (in_req_type == gbte_pkg::REQ_BACKWARD);
            rem_nxt  = 12'd1;
          end
        end
      end
      gbte_pkg::S_EXEC: begin
        unique case (req_r)
          gbte_pkg::REQ_INSERT: begin
            if (full) begin
              res_status_nxt = gbte_pkg::ST_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = ADDR_W'(before_len_r);
              ram_wdata      = char_r;
              before_len_nxt = before_len_r + LEN_W'(1);
            end
          end
          gbte_pkg::REQ_FORWARD, gbte_pkg::REQ_BACKWARD, gbte_pkg::REQ_MOVE: begin
            if (rem_r != '0) begin
              if (step_ok) begin
                ram_re    = 1'b1;
                ram_raddr = back_r ? ADDR_W'(before_len_r - LEN_W'(1))
                                   : ADDR_W'(CAP_LEN - after_len_r);
                rem_nxt   = rem_r - 12'd1;
              end else begin
                res_status_nxt = gbte_pkg::ST_NOEFFECT;
              end
            end
          end
          gbte_pkg::REQ_BACKSPACE: begin
            if (before_len_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(before_len_r - LEN_W'(1));
            end else begin
              res_status_nxt = gbte_pkg::ST_NOEFFECT;
            end
          end
          gbte_pkg::REQ_DELETE: begin
            if (after_len_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(CAP_LEN - after_len_r);
            end else begin
              res_status_nxt = gbte_pkg::ST_NOEFFECT;
            end
          end
          gbte_pkg::REQ_READ: begin
            if (pos_ext < total_ext) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(read_addr);
            end else begin
              res_status_nxt = gbte_pkg::ST_RANGE;
            end
          end
          default: res_status_nxt = gbte_pkg::ST_NOEFFECT;
        endcase
      end
      gbte_pkg::S_DATA: begin
        unique case (req_r)
          gbte_pkg::REQ_BACKSPACE: begin
            res_char_nxt   = ram_rdata;
            before_len_nxt = before_len_r - LEN_W'(1);
          end
          gbte_pkg::REQ_DELETE: begin
            res_char_nxt  = ram_rdata;
            after_len_nxt = after_len_r - LEN_W'(1);
          end
          gbte_pkg::REQ_READ: begin
            res_char_nxt = ram_rdata;
          end
          default: begin
            // Carry one character across the gap
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (back_r) begin
              ram_waddr      = ADDR_W'(CAP_LEN - after_len_r - LEN_W'(1));
              before_len_nxt = before_len_r - LEN_W'(1);
              after_len_nxt  = after_len_r + LEN_W'(1);
            end else begin
              ram_waddr      = ADDR_W'(before_len_r);
              before_len_nxt = before_len_r + LEN_W'(1);
              after_len_nxt  = after_len_r - LEN_W'(1);
            end
          end
        endcase
      end
      gbte_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gbte_pkg::S_IDLE;
      before_len_r <= '0;
      after_len_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      before_len_r <= before_len_nxt;
      after_len_r  <= after_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    char_r       <= char_nxt;
    back_r       <= back_nxt;
    rem_r        <= rem_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_char_r   <= res_char_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_char_r   <= res_char_r;
      out_before_r <= before_len_r;
      out_after_r  <= after_len_r;
    end
  end

  assign before_ext_out = {11'd0, out_before_r};
  assign after_ext_out  = {11'd0, out_after_r};

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_char_out     = out_char_r;
  assign out_before_count = before_ext_out[10:0];
  assign out_after_count  = after_ext_out[10:0];

endmodule

// ----- tb/gap_buffer_text_editor_top_tb.sv -----
// Self-checking testbench for the gap buffer text editor top level.
`timescale 1ns / 1ps

module gap_buffer_text_editor_top_tb;

  localparam int CAP = 1024;
  localparam int IDX_W = $clog2(CAP);
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct {
    gbte_pkg::status_t st;
    logic [7:0]        ch;
    logic [10:0]       pre;
    logic [10:0]       post;
  } edit_result_t;

  // Tracks the text as the block should hold it and queues the expected results.
  class gap_edit_tracker;
    logic [7:0] text_mem [CAP];
    int unsigned pre_len;
    int unsigned post_len;
    edit_result_t pending[$];
    int mismatches;

    function new();
      pre_len = 0;
      post_len = 0;
      mismatches = 0;
    endfunction

    function logic [IDX_W-1:0] slot(int unsigned idx);
      return IDX_W'(idx % CAP);
    endfunction

    function bit cursor_back();
      if (pre_len == 0) return 1'b0;
      text_mem[slot(CAP - post_len - 1)] = text_mem[slot(pre_len - 1)];
      pre_len--;
      post_len++;
      return 1'b1;
    endfunction

    function bit cursor_fwd();
      if (post_len == 0) return 1'b0;
      text_mem[slot(pre_len)] = text_mem[slot(CAP - post_len)];
      pre_len++;
      post_len--;
      return 1'b1;
    endfunction

    function void note_command(logic [2:0] req, logic [7:0] ch, logic signed [11:0] amt,
                               logic [9:0] pos);
      edit_result_t r;
      int mag;
      bit back;
      int i;
      r.st = gbte_pkg::ST_DONE;
      r.ch = 8'h00;
      case (req)
        gbte_pkg::REQ_INSERT: begin
          if (pre_len + post_len >= CAP) r.st = gbte_pkg::ST_FULL;
          else begin
            text_mem[slot(pre_len)] = ch;
            pre_len++;
          end
        end
        gbte_pkg::REQ_FORWARD:  if (!cursor_fwd()) r.st = gbte_pkg::ST_NOEFFECT;
        gbte_pkg::REQ_BACKWARD: if (!cursor_back()) r.st = gbte_pkg::ST_NOEFFECT;
        gbte_pkg::REQ_BACKSPACE: begin
          if (pre_len == 0) r.st = gbte_pkg::ST_NOEFFECT;
          else begin
            r.ch = text_mem[slot(pre_len - 1)];
            pre_len--;
          end
        end
        gbte_pkg::REQ_DELETE: begin
          if (post_len == 0) r.st = gbte_pkg::ST_NOEFFECT;
          else begin
            r.ch = text_mem[slot(CAP - post_len)];
            post_len--;
          end
        end
        gbte_pkg::REQ_MOVE: begin
          back = amt[11];
          mag = back ? -int'(amt) : int'(amt);
          for (i = 0; i < mag; i++) begin
            if (!(back ? cursor_back() : cursor_fwd())) begin
              r.st = gbte_pkg::ST_NOEFFECT;
              break;
            end
          end
        end
        gbte_pkg::REQ_READ: begin
          if (pos < pre_len) r.ch = text_mem[pos];
          else if (pos - pre_len < post_len)
            r.ch = text_mem[slot(CAP - post_len + (pos - pre_len))];
          else r.st = gbte_pkg::ST_RANGE;
        end
        default: r.st = gbte_pkg::ST_NOEFFECT;
      endcase
      r.pre = pre_len[10:0];
      r.post = post_len[10:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] ch, logic [10:0] pre,
                               logic [10:0] post);
      edit_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result beat: status %0d char %0h", st, ch);
        mismatches++;
        return;
      end
      r = pending.pop_front();
      if (st !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, st);
        mismatches++;
      end
      if (ch !== r.ch) begin
        $error("char_out: expected %0h, got %0h", r.ch, ch);
        mismatches++;
      end
      if (pre !== r.pre) begin
        $error("before_count: expected %0d, got %0d", r.pre, pre);
        mismatches++;
      end
      if (post !== r.post) begin
        $error("after_count: expected %0d, got %0d", r.post, post);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic [7:0]         in_char_in;
  logic signed [11:0] in_move_amount;
  logic [9:0]         in_position;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [7:0]         out_char_out;
  logic [10:0]        out_before_count;
  logic [10:0]        out_after_count;

  gap_edit_tracker tracker = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  gap_buffer_text_editor_top #(.CAPACITY(CAP)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_char_in       (in_char_in),
    .in_move_amount   (in_move_amount),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_char_out     (out_char_out),
    .out_before_count (out_before_count),
    .out_after_count  (out_after_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check each beat, stall in random bursts.
  initial begin : result_sink
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_result(out_status, out_char_out, out_before_count, out_after_count);
      if (hold > 0) hold--;
      else if ($urandom_range(0, 99) < stall_pct) hold = int'($urandom_range(1, 11));
      out_stall <= (hold > 0);
    end
  end

  task automatic send_command(input logic [2:0] req, input logic [7:0] ch,
                              input logic signed [11:0] amt, input logic [9:0] pos);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_char_in     <= ch;
    in_move_amount <= amt;
    in_position    <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(req, ch, amt, pos);
  endtask

  // Drop valid and hold until every expected beat has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_edit();
    int pick;
    int total;
    logic [2:0] req;
    logic [7:0] ch;
    logic signed [11:0] amt;
    logic [9:0] pos;
    total = int'(tracker.pre_len + tracker.post_len);
    ch = 8'($urandom);
    amt = 12'($urandom);
    pos = 10'($urandom);
    pick = int'($urandom_range(0, 99));
    if (pick < 40) req = gbte_pkg::REQ_INSERT;
    else if (pick < 47) req = gbte_pkg::REQ_FORWARD;
    else if (pick < 54) req = gbte_pkg::REQ_BACKWARD;
    else if (pick < 61) req = gbte_pkg::REQ_BACKSPACE;
    else if (pick < 68) req = gbte_pkg::REQ_DELETE;
    else if (pick < 84) begin
      req = gbte_pkg::REQ_MOVE;
      // mostly short hops; the rest span the whole signed range
      if ($urandom_range(0, 3) != 0) amt = 12'($urandom_range(0, 32)) - 12'd16;
    end else if (pick < 98) begin
      req = gbte_pkg::REQ_READ;
      if ($urandom_range(0, 4) != 0)
        pos = 10'($urandom_range(0, total > 1023 ? 1023 : total));
    end else req = REQ_UNUSED;
    send_command(req, ch, amt, pos);
  endtask

  initial begin : stimulus
    int n;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= gbte_pkg::REQ_INSERT;
    in_char_in     <= 8'h00;
    in_move_amount <= 12'sd0;
    in_position    <= 10'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty text, then a four-character text: edge cases at both ends
    send_command(gbte_pkg::REQ_BACKSPACE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_DELETE, 8'hFF, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_FORWARD, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_BACKWARD, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, -12'sd2048, 10'd0);
    send_command(REQ_UNUSED, 8'hFF, -12'sd1, 10'd1023);
    send_command(gbte_pkg::REQ_INSERT, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'hFF, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'hA5, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'h5A, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd3);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd1023);
    send_command(gbte_pkg::REQ_BACKWARD, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, -12'sd2048, 10'd0);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd2);
    send_command(gbte_pkg::REQ_DELETE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, 12'sd2047, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, -12'sd1, 10'd0);
    send_command(gbte_pkg::REQ_BACKSPACE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, 12'sd1, 10'd0);
    send_command(gbte_pkg::REQ_FORWARD, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'h80, 12'sd0, 10'd0);
    wait_for_results();

    // random edits; idling levels change every 20 beats
    for (n = 0; n < 60; n++) begin
      if (n % 20 == 0) begin
        idle_pct  = $urandom_range(0, 2) * 20;
        stall_pct = $urandom_range(0, 2) * 15;
      end
      if (n % 30 == 29) wait_for_results();
      send_random_edit();
    end
    wait_for_results();

    // grow the text to capacity, wandering the cursor now and then
    idle_pct  = 10;
    stall_pct = 10;
    while (tracker.pre_len + tracker.post_len < CAP) begin
      if ($urandom_range(0, 19) == 0)
        send_command(gbte_pkg::REQ_MOVE, 8'($urandom),
                     12'($urandom_range(0, 64)) - 12'd32, 10'($urandom));
      else
        send_command(gbte_pkg::REQ_INSERT, 8'($urandom), 12'($urandom), 10'($urandom));
    end

    // full store, then the final stretch without idling
    idle_pct  = 0;
    stall_pct = 0;
    send_command(gbte_pkg::REQ_INSERT, 8'h3C, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'hC3, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd1023);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, -12'sd2048, 10'd0);
    send_command(gbte_pkg::REQ_READ, 8'h00, 12'sd0, 10'd1023);
    send_command(gbte_pkg::REQ_MOVE, 8'h00, 12'sd2047, 10'd0);
    send_command(gbte_pkg::REQ_DELETE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_BACKSPACE, 8'h00, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'h11, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'h22, 12'sd0, 10'd0);
    send_command(gbte_pkg::REQ_INSERT, 8'h33, 12'sd0, 10'd0);
    for (n = 0; n < 24; n++) send_random_edit();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
